### src/bm25_query_score_core_assert.svh
// assertion macros shared by the bm25 score core
`ifndef BM25_QUERY_SCORE_CORE_ASSERT_SVH
`define BM25_QUERY_SCORE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BQS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bqs_pkg.sv
// types, constants and codes of the bm25 score core
package bqs_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int CNT_W          = 32;
	localparam int BOOST_W        = 16;
	localparam int SCORE_W        = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam int K1_W   = 16;
	localparam int B_W    = 13;
	localparam int AVG_W  = 32;

	localparam logic [K1_W-1:0]  K1_RST  = 16'd4915;
	localparam logic [B_W-1:0]   B_RST   = 13'd3072;
	localparam logic [AVG_W-1:0] AVG_RST = 32'd256;
	localparam logic [B_W-1:0]   B_ONE   = 13'd4096;
	localparam logic [AVG_W-1:0] AVG_ONE = 32'd256;
	localparam logic [16:0]      K1_ONE  = 17'd4096;
	localparam logic [31:0]      LN2_Q32 = 32'd2977044472;

	localparam int LOG_X_W  = 34;
	localparam int MANT_W   = 31;
	localparam int LOG_R_W  = 26;
	localparam int DVS_W    = 53;
	localparam int DSH_W    = 48;
	localparam int NORM_W   = 49;
	localparam int NUM_W    = 49;
	localparam int IDF_W    = 22;
	localparam int TFC_W    = 21;
	localparam int PROD_W   = 27;
	localparam int TERM_W   = 35;
	localparam int SUM_W    = 48;

	localparam int STEP_W      = 6;
	localparam int NORM_STEPS  = 6;
	localparam int SQ_STEPS    = 20;
	localparam int RDIV_STEPS  = 48;
	localparam int TDIV_STEPS  = 21;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_K1   = 2'd0,
		CFG_B    = 2'd1,
		CFG_AVG  = 2'd2,
		CFG_NDOC = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_LOG_INIT_A, OP_LOG_INIT_B, OP_LOG_NORM, OP_LOG_MANT,
		OP_LOG_SQ, OP_IDF, OP_RDIV_INIT, OP_TDIV_INIT, OP_DIV_STEP, OP_NORM,
		OP_DEN, OP_TFC, OP_PROD, OP_SCALE, OP_ACCUM
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOGA_INIT, ST_LOGA_NORM, ST_LOGA_MANT, ST_LOGA_SQ,
		ST_LOGB_INIT, ST_LOGB_NORM, ST_LOGB_MANT, ST_LOGB_SQ, ST_IDF,
		ST_RDIV_INIT, ST_RDIV, ST_NORM, ST_DEN, ST_TDIV_INIT, ST_TDIV,
		ST_TFC, ST_PROD, ST_SCALE, ST_ACCUM
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic excluded;
		logic last;
		logic out_busy;
	} dp_status_t;

endpackage

### src/bqs_term_if.sv
// request channels: query terms in, document score out
interface bqs_term_if import bqs_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic [CNT_W-1:0]          dfreq;
	logic                      dfreq_given;
	logic [CNT_W-1:0]          tfreq;
	logic                      tfreq_given;
	logic [CNT_W-1:0]          dlen;
	logic                      dlen_given;
	logic signed [BOOST_W-1:0] boost;
	logic                      excluded;
	logic                      last_term;

	modport source (output valid, dfreq, dfreq_given, tfreq, tfreq_given,
		dlen, dlen_given, boost, excluded, last_term, input ready);
	modport sink (input valid, dfreq, dfreq_given, tfreq, tfreq_given,
		dlen, dlen_given, boost, excluded, last_term, output ready);
endinterface

interface bqs_score_if import bqs_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score;

	modport source (output valid, score, input ready);
	modport sink (input valid, score, output ready);
endinterface

### src/bqs_datapath.sv
// datapath: config registers, log unit, shared divider, multipliers, running sum
module bqs_datapath import bqs_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	input  logic [CNT_W-1:0]          dfreq,
	input  logic                      dfreq_given,
	input  logic [CNT_W-1:0]          tfreq,
	input  logic                      tfreq_given,
	input  logic [CNT_W-1:0]          dlen,
	input  logic                      dlen_given,
	input  logic signed [BOOST_W-1:0] boost,
	input  logic                      excluded,
	input  logic                      last_term,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [SCORE_W-1:0]        out_score
);

	logic [K1_W-1:0]  k1_q;
	logic [B_W-1:0]   b_q;
	logic [AVG_W-1:0] avg_q;
	logic [CNT_W-1:0] ndoc_q;

	logic [COUNT_BITS-1:0] df_q, tf_q;
	logic [CNT_W-1:0]      len_q;
	logic [BOOST_W-1:0]    boost_q;
	logic                  excl_q, last_q;

	logic [LOG_X_W-1:0] x_q;
	logic [5:0]         e_q;
	logic [MANT_W-1:0]  m_q;
	logic [LOG_R_W-1:0] r_q, la_q;
	logic [IDF_W-1:0]   idf_q;

	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DSH_W-1:0] dsh_q, quo_q;
	logic [NORM_W-1:0] norm_q;
	logic [DVS_W-1:0]  den_q;
	logic [NUM_W-1:0]  num_q;
	logic [TFC_W-1:0]  tfc_q;
	logic [PROD_W-1:0] p_q;
	logic [TERM_W-1:0] term_q;

	logic [SUM_W-1:0]   sum_q;
	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;

	// derived operands
	logic [AVG_W-1:0]      avg_eff;
	logic [B_W-1:0]        b_eff;
	logic [COUNT_BITS-1:0] ndoc_m, total;
	logic                  idf_ok;
	logic [CNT_W-1:0]      len_in;

	always_comb begin
		avg_eff = (avg_q < AVG_ONE) ? AVG_ONE : avg_q;
		b_eff   = (b_q > B_ONE) ? B_ONE : b_q;
		ndoc_m  = ndoc_q[COUNT_BITS-1:0];
		total   = (ndoc_m == '0) ? COUNT_BITS'(1) : ndoc_m;
		idf_ok  = (df_q != '0) && (df_q <= total);
		len_in  = dlen_given ? CNT_W'(dlen[COUNT_BITS-1:0])
			: CNT_W'(avg_q[AVG_W-1:8]);
		if (len_in == '0)
			len_in = CNT_W'(1);
	end

	// log unit
	logic [5:0]         nsh;
	logic [LOG_X_W-1:0] nhi;
	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]    sqt;
	logic [4:0]         rbit;
	logic [LOG_R_W-1:0] ldiff;

	always_comb begin
		nsh   = 6'd32 >> cmd.step;
		nhi   = x_q >> (6'd34 - nsh);
		sq    = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
		sqt   = sq[2*MANT_W-1:MANT_W-1];
		rbit  = 5'd19 - cmd.step[4:0];
		ldiff = (la_q > r_q) ? (la_q - r_q) : '0;
	end

	// divider step
	logic [DVS_W:0] trial, tdiff;
	logic           tge;

	always_comb begin
		trial = {rem_q, dsh_q[DSH_W-1]};
		tge   = trial >= {1'b0, dvs_q};
		tdiff = trial - {1'b0, dvs_q};
	end

	// multiplier products
	logic [61:0] norm_full;
	logic [63:0] kn;
	logic [57:0] idf_full;
	logic [42:0] prod_full, scale_full;
	logic [BOOST_W-1:0] bmag;

	always_comb begin
		norm_full  = (62'(B_ONE - b_eff) << 16) + 62'(b_eff) * 62'(quo_q);
		kn         = 64'(k1_q) * 64'(norm_q);
		idf_full   = 58'(ldiff) * 58'(LN2_Q32);
		prod_full  = 43'(idf_q) * 43'(tfc_q);
		bmag       = boost_q[BOOST_W-1] ? (~boost_q + BOOST_W'(1)) : boost_q;
		scale_full = 43'(p_q) * 43'(bmag);
	end

	// running sum update
	logic signed [SUM_W:0] sum_ext, add_v, sum_wide;
	logic [SUM_W-1:0]      sum_nxt;
	logic [SCORE_W-1:0]    score_v;

	always_comb begin
		sum_ext = {sum_q[SUM_W-1], sum_q};
		if (excl_q)
			add_v = '0;
		else if (boost_q[BOOST_W-1])
			add_v = -$signed((SUM_W+1)'(term_q));
		else
			add_v = $signed((SUM_W+1)'(term_q));
		sum_wide = sum_ext + add_v;
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_nxt = sum_wide[SUM_W-1:0];
		score_v = '0;
		if (ndoc_m != '0 && !sum_nxt[SUM_W-1] && sum_nxt != '0)
			score_v = (|sum_nxt[SUM_W-2:SCORE_W]) ? '1 : sum_nxt[SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q   <= K1_RST;
			b_q    <= B_RST;
			avg_q  <= AVG_RST;
			ndoc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_K1:   k1_q   <= cfg_data[K1_W-1:0];
				CFG_B:    b_q    <= cfg_data[B_W-1:0];
				CFG_AVG:  avg_q  <= cfg_data[AVG_W-1:0];
				CFG_NDOC: ndoc_q <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				df_q    <= dfreq_given ? dfreq[COUNT_BITS-1:0] : COUNT_BITS'(1);
				tf_q    <= tfreq_given ? tfreq[COUNT_BITS-1:0] : COUNT_BITS'(1);
				len_q   <= len_in;
				boost_q <= boost;
				excl_q  <= excluded;
				last_q  <= last_term;
			end
			OP_LOG_INIT_A: begin
				x_q <= (LOG_X_W'(total) << 1) + LOG_X_W'(2);
				e_q <= 6'd33;
			end
			OP_LOG_INIT_B: begin
				x_q  <= (LOG_X_W'(df_q) << 1) + LOG_X_W'(1);
				e_q  <= 6'd33;
				la_q <= r_q;
			end
			OP_LOG_NORM: begin
				if (nhi == '0) begin
					x_q <= x_q << nsh;
					e_q <= e_q - nsh;
				end
			end
			OP_LOG_MANT: begin
				m_q <= x_q[LOG_X_W-1:3];
				r_q <= LOG_R_W'(e_q) << 20;
			end
			OP_LOG_SQ: begin
				if (sqt[MANT_W]) begin
					m_q       <= sqt[MANT_W:1];
					r_q[rbit] <= 1'b1;
				end else begin
					m_q <= sqt[MANT_W-1:0];
				end
			end
			OP_IDF: idf_q <= idf_ok ? IDF_W'(idf_full >> 36) : '0;
			OP_RDIV_INIT: begin
				rem_q <= DVS_W'(len_q[31:24]);
				dsh_q <= {len_q[23:0], 24'd0};
				dvs_q <= DVS_W'(avg_eff);
				quo_q <= '0;
			end
			OP_TDIV_INIT: begin
				rem_q <= DVS_W'(num_q >> 1);
				dsh_q <= {num_q[0], {(DSH_W-1){1'b0}}};
				dvs_q <= den_q;
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= tge ? tdiff[DVS_W-1:0] : trial[DVS_W-1:0];
				dsh_q <= dsh_q << 1;
				quo_q <= {quo_q[DSH_W-2:0], tge};
			end
			OP_NORM: norm_q <= NORM_W'(norm_full >> 12);
			OP_DEN: begin
				den_q <= (DVS_W'(tf_q) << 16) + DVS_W'(kn >> 12);
				num_q <= NUM_W'(tf_q) * NUM_W'(K1_ONE + 17'(k1_q));
			end
			OP_TFC:   tfc_q  <= (tf_q == '0) ? '0 : quo_q[TFC_W-1:0];
			OP_PROD:  p_q    <= PROD_W'(prod_full >> 16);
			OP_SCALE: term_q <= TERM_W'(scale_full >> 8);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ACCUM && last_q) begin
				sum_q       <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (cmd.op == OP_ACCUM)
					sum_q <= sum_nxt;
				if (out_valid_q && out_ready)
					out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCUM && last_q)
			out_score_q <= score_v;
	end

	assign out_valid       = out_valid_q;
	assign out_score       = out_score_q;
	assign status.excluded = excl_q;
	assign status.last     = last_q;
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

### src/bqs_ctrl.sv
// controller: sequences one term through the datapath
`include "bm25_query_score_core_assert.svh"
module bqs_ctrl import bqs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       term_valid,
	output logic       term_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t            state_q, state_nxt;
	logic [STEP_W-1:0] count_q, count_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		count_nxt  = count_q;
		cmd.op     = OP_NONE;
		cmd.step   = count_q;
		term_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				term_ready = 1'b1;
				if (term_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = ST_LOGA_INIT;
				end
			end
			ST_LOGA_INIT: begin
				count_nxt = '0;
				if (status.excluded) begin
					state_nxt = ST_ACCUM;
				end else begin
					cmd.op    = OP_LOG_INIT_A;
					state_nxt = ST_LOGA_NORM;
				end
			end
			ST_LOGA_NORM, ST_LOGB_NORM: begin
				cmd.op = OP_LOG_NORM;
				if (count_q == STEP_W'(NORM_STEPS - 1)) begin
					count_nxt = '0;
					state_nxt = (state_q == ST_LOGA_NORM) ? ST_LOGA_MANT : ST_LOGB_MANT;
				end else begin
					count_nxt = count_q + STEP_W'(1);
				end
			end
			ST_LOGA_MANT: begin
				cmd.op    = OP_LOG_MANT;
				state_nxt = ST_LOGA_SQ;
			end
			ST_LOGB_MANT: begin
				cmd.op    = OP_LOG_MANT;
				state_nxt = ST_LOGB_SQ;
			end
			ST_LOGA_SQ, ST_LOGB_SQ: begin
				cmd.op = OP_LOG_SQ;
				if (count_q == STEP_W'(SQ_STEPS - 1)) begin
					count_nxt = '0;
					state_nxt = (state_q == ST_LOGA_SQ) ? ST_LOGB_INIT : ST_IDF;
				end else begin
					count_nxt = count_q + STEP_W'(1);
				end
			end
			ST_LOGB_INIT: begin
				cmd.op    = OP_LOG_INIT_B;
				state_nxt = ST_LOGB_NORM;
			end
			ST_IDF: begin
				cmd.op    = OP_IDF;
				state_nxt = ST_RDIV_INIT;
			end
			ST_RDIV_INIT: begin
				cmd.op    = OP_RDIV_INIT;
				count_nxt = '0;
				state_nxt = ST_RDIV;
			end
			ST_RDIV: begin
				cmd.op = OP_DIV_STEP;
				if (count_q == STEP_W'(RDIV_STEPS - 1)) begin
					count_nxt = '0;
					state_nxt = ST_NORM;
				end else begin
					count_nxt = count_q + STEP_W'(1);
				end
			end
			ST_NORM: begin
				cmd.op    = OP_NORM;
				state_nxt = ST_DEN;
			end
			ST_DEN: begin
				cmd.op    = OP_DEN;
				state_nxt = ST_TDIV_INIT;
			end
			ST_TDIV_INIT: begin
				cmd.op    = OP_TDIV_INIT;
				count_nxt = '0;
				state_nxt = ST_TDIV;
			end
			ST_TDIV: begin
				cmd.op = OP_DIV_STEP;
				if (count_q == STEP_W'(TDIV_STEPS - 1)) begin
					count_nxt = '0;
					state_nxt = ST_TFC;
				end else begin
					count_nxt = count_q + STEP_W'(1);
				end
			end
			ST_TFC: begin
				cmd.op    = OP_TFC;
				state_nxt = ST_PROD;
			end
			ST_PROD: begin
				cmd.op    = OP_PROD;
				state_nxt = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op    = OP_SCALE;
				state_nxt = ST_ACCUM;
			end
			ST_ACCUM: begin
				if (!(status.last && status.out_busy)) begin
					cmd.op    = OP_ACCUM;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	`BQS_ASSERT_NEXT(a_busy_after_request, clk, arst_n, term_valid && term_ready, !term_ready, "request taken while a term is in flight")
	`BQS_ASSERT_HOLDS(a_no_score_overwrite, clk, arst_n, cmd.op == OP_ACCUM && status.last, !status.out_busy, "pending score overwritten")
	`BQS_ASSERT_HOLDS(a_norm_step_range, clk, arst_n, cmd.op == OP_LOG_NORM, cmd.step < STEP_W'(NORM_STEPS), "normalise step out of range")

endmodule

### src/bm25_query_score_core.sv
// top level of the bm25 score core: controller plus datapath
// a new term is taken only once the previous one is done; excluded terms skip to accumulate
// time set by two log2 passes and a bit-serial divider run for 48 then 21 steps
// a final term's score becomes valid when its accumulate step runs, which is held back
// while an earlier score still waits for the sink
// reset (arst_n low) clears the sum and the score valid flag and loads the register defaults
module bm25_query_score_core import bqs_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes, one register per write
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// query terms in, document score out
	bqs_term_if.sink              term,
	bqs_score_if.source           result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: walks log, idf, length ratio, tf division, scaling and accumulate
	bqs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_valid (term.valid),
		.term_ready (term.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// arithmetic and the running sum; the score register decouples the output side
	bqs_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.dfreq       (term.dfreq),
		.dfreq_given (term.dfreq_given),
		.tfreq       (term.tfreq),
		.tfreq_given (term.tfreq_given),
		.dlen        (term.dlen),
		.dlen_given  (term.dlen_given),
		.boost       (term.boost),
		.excluded    (term.excluded),
		.last_term   (term.last_term),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_score   (result.score)
	);

endmodule
